/* design/tfn_pkg.sv */
// Package for the triangle face normal expander.
// Holds field widths, internal arithmetic widths, operation and corner codes and shared types.
// Has no dependencies; every other design file but tfn_ram imports it.
`default_nettype none

package tfn_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned IndexW = 12;
    localparam int unsigned CoordW = 24;
    localparam int unsigned NormW  = 16;

    // Default vertex store depth.
    localparam int unsigned VertexDepthDefault = 4096;

    // Operation codes.
    localparam logic OpWrite = 1'b0;
    localparam logic OpFace  = 1'b1;

    // Corner codes, used both for the read sequence and the result sequence.
    localparam logic [1:0] CornerA = 2'd0;
    localparam logic [1:0] CornerB = 2'd1;
    localparam logic [1:0] CornerC = 2'd2;

    // Internal arithmetic widths.
    localparam int unsigned DiffW  = CoordW + 1;      // edge vector component
    localparam int unsigned CrossW = 2 * DiffW;       // cross product component
    localparam int unsigned MagW   = CrossW - 1;      // cross product magnitude
    localparam int unsigned GrpW   = 7;               // leading-one search group
    localparam int unsigned GrpN   = MagW / GrpW;     // number of groups
    localparam int unsigned BlW    = 6;               // bit length of a magnitude
    localparam int unsigned NMagW  = 30;              // normalized magnitude
    localparam int unsigned SqW    = 2 * NMagW;       // square of one magnitude
    localparam int unsigned SumW   = SqW + 2;         // sum of three squares
    localparam int unsigned RootW  = SumW / 2;        // square root of the sum
    localparam int unsigned QuotW  = 16;              // normal magnitude before clamp
    localparam int unsigned QShift = 15;              // scale of the dividend
    localparam int unsigned NumW   = NMagW + QShift + 1;
    localparam int unsigned DenW   = RootW + 1;

    localparam logic [QuotW-1:0] QuotMax = QuotW'(16384);

    // One vertex position.
    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
    } t_pos;

    // The three corner positions of one face.
    typedef struct packed {
        t_pos a;
        t_pos b;
        t_pos c;
    } t_face;

endpackage

`default_nettype wire

/* design/tfn_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the vertex store; depends on nothing.
`default_nettype none

module tfn_ram #(
    parameter int unsigned WIDTH = 72,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read data holds while the read is idle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* design/tfn_fetch.sv */
// Input stage: vertex store writes and the corner read sequence of a face, a then b then c.
// Depends on tfn_pkg and tfn_ram; hands a complete face word to the normal pipeline.
`default_nettype none

module tfn_fetch
    import tfn_pkg::*;
#(
    parameter int unsigned VERTEX_DEPTH = VertexDepthDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_operation,
    input  logic [IndexW-1:0]        i_vertex_index,
    input  logic signed [CoordW-1:0] i_pos_x_in,
    input  logic signed [CoordW-1:0] i_pos_y_in,
    input  logic signed [CoordW-1:0] i_pos_z_in,
    input  logic [IndexW-1:0]        i_corner_a,
    input  logic [IndexW-1:0]        i_corner_b,
    input  logic [IndexW-1:0]        i_corner_c,
    output logic                     o_face_valid,
    output t_face                    o_face
);

    localparam int unsigned AddrW = $clog2(VERTEX_DEPTH);
    localparam int unsigned ExtW  = IndexW + AddrW;

    logic [1:0]        r_step;
    logic [1:0]        n_step;
    logic [IndexW-1:0] r_corner_b;
    logic [IndexW-1:0] r_corner_c;

    logic              w_accept;
    logic              w_face_start;
    logic [IndexW-1:0] w_rd_idx;
    logic [ExtW-1:0]   w_rd_ext;
    logic [ExtW-1:0]   w_wr_ext;
    logic              w_rd_issue;
    logic              w_rd_zero;
    logic              w_wr_en;
    t_pos              w_wr_pos;
    t_pos              w_rd_data;
    t_pos              w_rd_pos;

    logic              r_rd_valid;
    logic [1:0]        r_rd_slot;
    logic              r_rd_zero;
    t_pos              r_pa;
    t_pos              r_pb;
    logic              r_face_valid;
    t_face             r_face;

    // A face holds the input while corners b and c are read.
    assign o_stall      = !i_en || (r_step != CornerA);
    assign w_accept     = i_valid && !o_stall;
    assign w_face_start = w_accept && (i_operation == OpFace);

    // Read index for this cycle: corner a straight from the input, then b and c.
    always_comb begin
        unique case (r_step)
            CornerA: w_rd_idx = i_corner_a;
            CornerB: w_rd_idx = r_corner_b;
            CornerC: w_rd_idx = r_corner_c;
            default: w_rd_idx = i_corner_a;
        endcase
    end

    assign w_rd_issue = i_en && ((r_step != CornerA) || w_face_start);
    assign w_rd_zero  = !(32'(w_rd_idx) < 32'(VERTEX_DEPTH));
    assign w_rd_ext   = ExtW'(w_rd_idx);
    assign w_wr_ext   = ExtW'(i_vertex_index);
    assign w_wr_en    = w_accept && (i_operation == OpWrite)
                        && (32'(i_vertex_index) < 32'(VERTEX_DEPTH));
    assign w_wr_pos   = '{x: i_pos_x_in, y: i_pos_y_in, z: i_pos_z_in};

    tfn_ram #(
        .WIDTH ($bits(t_pos)),
        .DEPTH (VERTEX_DEPTH)
    ) u_vertex_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_ext[AddrW-1:0]),
        .i_wr_data (w_wr_pos),
        .i_rd_en   (w_rd_issue),
        .i_rd_addr (w_rd_ext[AddrW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Read sequencer.
    always_comb begin
        unique case (r_step)
            CornerA: n_step = w_face_start ? CornerB : CornerA;
            CornerB: n_step = CornerC;
            CornerC: n_step = CornerA;
            default: n_step = CornerA;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= CornerA;
            r_rd_valid   <= 1'b0;
            r_face_valid <= 1'b0;
        end else if (i_en) begin
            r_step       <= n_step;
            r_rd_valid   <= w_rd_issue;
            r_face_valid <= r_rd_valid && (r_rd_slot == CornerC);
        end
    end

    // Indices out of the store's range read as position zero.
    assign w_rd_pos = r_rd_zero ? t_pos'('0) : w_rd_data;

    // Corner capture; the face word is complete when corner c arrives.
    always_ff @(posedge i_clk) begin
        if (w_face_start) begin
            r_corner_b <= i_corner_b;
            r_corner_c <= i_corner_c;
        end
        if (i_en) begin
            r_rd_slot <= r_step;
            r_rd_zero <= w_rd_zero;
            if (r_rd_valid) begin
                unique case (r_rd_slot)
                    CornerA: r_pa <= w_rd_pos;
                    CornerB: r_pb <= w_rd_pos;
                    CornerC: r_face <= '{a: r_pa, b: r_pb, c: w_rd_pos};
                    default: r_pa <= w_rd_pos;
                endcase
            end
        end
    end

    assign o_face_valid = r_face_valid;
    assign o_face       = r_face;

endmodule

`default_nettype wire

/* design/tfn_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with a side word carried along.
// Depends on tfn_pkg for the operand widths.
`default_nettype none

module tfn_isqrt
    import tfn_pkg::*;
#(
    parameter int unsigned SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SumW-1:0]   i_x,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [RootW-1:0]  o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int unsigned Steps = SumW / 2 + 1;
    localparam int unsigned ResW  = SumW + 2;

    logic [SumW-1:0]   r_rem  [Steps+1];
    logic [ResW-1:0]   r_res  [Steps+1];
    logic [SIDE_W-1:0] r_side [Steps+1];
    logic [Steps:0]    r_v;

    // Operand register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_x;
            r_res[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    // One trial subtraction per stage, from the top pair of bits down.
    for (genvar s = 0; s < Steps; s++) begin : g_step
        localparam logic [ResW-1:0] Bit = ResW'(1) << (2 * (Steps - 1 - s));
        logic [ResW-1:0] w_trial;
        logic            w_take;

        assign w_trial = r_res[s] + Bit;
        assign w_take  = ResW'(r_rem[s]) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s+1] <= r_side[s];
                if (w_take) begin
                    r_rem[s+1] <= r_rem[s] - w_trial[SumW-1:0];
                    r_res[s+1] <= (r_res[s] >> 1) + Bit;
                end else begin
                    r_rem[s+1] <= r_rem[s];
                    r_res[s+1] <= r_res[s] >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[Steps];
    assign o_root  = r_res[Steps][RootW-1:0];
    assign o_side  = r_side[Steps];

endmodule

`default_nettype wire

/* design/tfn_div.sv */
// Three-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// Depends on tfn_pkg for the operand widths; carries a side word along.
`default_nettype none

module tfn_div
    import tfn_pkg::*;
#(
    parameter int unsigned SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NumW-1:0]   i_num [3],
    input  logic [DenW-1:0]   i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QuotW-1:0]  o_quot [3],
    output logic [SIDE_W-1:0] o_side
);

    localparam int unsigned CmpW = DenW + QuotW;

    logic [NumW-1:0]   r_rem  [QuotW+1][3];
    logic [QuotW-1:0]  r_quot [QuotW+1][3];
    logic [DenW-1:0]   r_den  [QuotW+1];
    logic [SIDE_W-1:0] r_side [QuotW+1];
    logic [QuotW:0]    r_v;

    // Operand register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k]  <= i_num[k];
                r_quot[0][k] <= '0;
            end
        end
    end

    // Stage s decides quotient bit QuotW-1-s in every lane.
    for (genvar s = 0; s < QuotW; s++) begin : g_step
        localparam int unsigned Sh = QuotW - 1 - s;
        logic [CmpW-1:0] w_sub;

        assign w_sub = CmpW'(r_den[s]) << Sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        for (genvar k = 0; k < 3; k++) begin : g_lane
            logic w_take;

            assign w_take = CmpW'(r_rem[s][k]) >= w_sub;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_take) begin
                        r_rem[s+1][k]  <= r_rem[s][k] - w_sub[NumW-1:0];
                        r_quot[s+1][k] <= r_quot[s][k] | (QuotW'(1) << Sh);
                    end else begin
                        r_rem[s+1][k]  <= r_rem[s][k];
                        r_quot[s+1][k] <= r_quot[s][k];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1]  <= r_den[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[QuotW];
    assign o_side  = r_side[QuotW];
    for (genvar k = 0; k < 3; k++) begin : g_out
        assign o_quot[k] = r_quot[QuotW][k];
    end

endmodule

`default_nettype wire

/* design/tfn_normal.sv */
// Face normal pipeline: edges, cross product, normalization, root, division and sign.
// Depends on tfn_pkg, tfn_isqrt and tfn_div; the face positions ride along.
`default_nettype none

module tfn_normal
    import tfn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_face                   i_face,
    output logic                    o_valid,
    output t_face                   o_face,
    output logic signed [NormW-1:0] o_normal_x,
    output logic signed [NormW-1:0] o_normal_y,
    output logic signed [NormW-1:0] o_normal_z
);

    localparam int unsigned RootSideW = $bits(t_face) + 3 + 1 + 3 * NMagW;
    localparam int unsigned DivSideW  = $bits(t_face) + 3 + 1;

    // Bit length of a narrow group.
    function automatic logic [2:0] grp_len(input logic [GrpW-1:0] g);
        logic [2:0] len;
        len = '0;
        for (int i = 0; i < GrpW; i++) begin
            if (g[i]) begin
                len = 3'(i + 1);
            end
        end
        return len;
    endfunction

    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v, r11_v, r12_v;
    t_face r1_face, r2_face, r3_face, r4_face, r5_face, r6_face, r7_face, r8_face;
    t_face r9_face, r10_face, r12_face;

    logic signed [DiffW-1:0]  r1_d1 [3];
    logic signed [DiffW-1:0]  r1_d2 [3];
    logic signed [CrossW-1:0] r2_p  [6];
    logic signed [CrossW-1:0] r3_c  [3];
    logic [MagW-1:0]          r4_mag [3];
    logic [MagW-1:0]          r5_mag [3];
    logic [MagW-1:0]          r6_mag [3];
    logic [MagW-1:0]          r7_mag [3];
    logic [2:0]               r4_neg, r5_neg, r6_neg, r7_neg, r8_neg, r9_neg, r10_neg;
    logic [MagW-1:0]          r5_max;
    logic [GrpN-1:0]          r6_gnz;
    logic [2:0]               r6_glen [GrpN];
    logic [BlW-1:0]           r7_bl;
    logic                     r7_zero, r8_zero, r9_zero, r10_zero;
    logic [NMagW-1:0]         r8_mag [3];
    logic [NMagW-1:0]         r9_mag [3];
    logic [NMagW-1:0]         r10_mag [3];
    logic [SqW-1:0]           r9_sq  [3];
    logic [SumW-1:0]          r10_sum;

    logic [MagW-1:0]          w4_max01;
    logic [BlW-1:0]           w7_bl;
    logic                     w7_zero;

    logic [RootSideW-1:0]     w_root_side_in;
    logic [RootSideW-1:0]     w_root_side_out;
    logic                     w_root_valid;
    logic [RootW-1:0]         w_root;
    t_face                    w11_face;
    logic [2:0]               w11_neg;
    logic                     w11_zero;
    logic [NMagW-1:0]         w11_mag [3];

    t_face                    r11_face;
    logic [2:0]               r11_neg;
    logic                     r11_zero;
    logic [NumW-1:0]          r11_num [3];
    logic [DenW-1:0]          r11_den;

    logic [DivSideW-1:0]      w_div_side_out;
    logic                     w_div_valid;
    logic [QuotW-1:0]         w_quot [3];
    t_face                    w12_face;
    logic [2:0]               w12_neg;
    logic                     w12_zero;
    logic [NormW-1:0]         w12_clamp [3];
    logic [NormW-1:0]         r12_norm [3];

    // Valid bits of the local stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
        end else if (i_en) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= w_root_valid;
            r12_v <= w_div_valid;
        end
    end

    assign w4_max01 = (r4_mag[1] > r4_mag[0]) ? r4_mag[1] : r4_mag[0];

    // Bit length of the largest magnitude from the group flags.
    always_comb begin
        w7_bl   = '0;
        w7_zero = 1'b1;
        for (int g = 0; g < GrpN; g++) begin
            if (r6_gnz[g]) begin
                w7_bl   = BlW'(g * GrpW) + BlW'(r6_glen[g]);
                w7_zero = 1'b0;
            end
        end
    end

    // Stages one to ten: edges, products, cross, magnitudes, normalization, squares and their sum.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Edge vectors b - a and c - a.
            r1_face  <= i_face;
            r1_d1[0] <= DiffW'(i_face.b.x) - DiffW'(i_face.a.x);
            r1_d1[1] <= DiffW'(i_face.b.y) - DiffW'(i_face.a.y);
            r1_d1[2] <= DiffW'(i_face.b.z) - DiffW'(i_face.a.z);
            r1_d2[0] <= DiffW'(i_face.c.x) - DiffW'(i_face.a.x);
            r1_d2[1] <= DiffW'(i_face.c.y) - DiffW'(i_face.a.y);
            r1_d2[2] <= DiffW'(i_face.c.z) - DiffW'(i_face.a.z);

            // Six partial products of the cross product.
            r2_face <= r1_face;
            r2_p[0] <= r1_d1[1] * r1_d2[2];
            r2_p[1] <= r1_d1[2] * r1_d2[1];
            r2_p[2] <= r1_d1[2] * r1_d2[0];
            r2_p[3] <= r1_d1[0] * r1_d2[2];
            r2_p[4] <= r1_d1[0] * r1_d2[1];
            r2_p[5] <= r1_d1[1] * r1_d2[0];

            // Cross product components.
            r3_face <= r2_face;
            r3_c[0] <= r2_p[0] - r2_p[1];
            r3_c[1] <= r2_p[2] - r2_p[3];
            r3_c[2] <= r2_p[4] - r2_p[5];

            // Signs and magnitudes.
            r4_face <= r3_face;
            for (int k = 0; k < 3; k++) begin
                r4_neg[k] <= r3_c[k][CrossW-1];
                r4_mag[k] <= r3_c[k][CrossW-1] ? MagW'(-r3_c[k]) : MagW'(r3_c[k]);
            end

            // Largest magnitude.
            r5_face <= r4_face;
            r5_neg  <= r4_neg;
            r5_mag  <= r4_mag;
            r5_max  <= (r4_mag[2] > w4_max01) ? r4_mag[2] : w4_max01;

            // Leading-one search, first half: per-group flags and lengths.
            r6_face <= r5_face;
            r6_neg  <= r5_neg;
            r6_mag  <= r5_mag;
            for (int g = 0; g < GrpN; g++) begin
                r6_gnz[g]  <= |r5_max[g*GrpW +: GrpW];
                r6_glen[g] <= grp_len(r5_max[g*GrpW +: GrpW]);
            end

            // Leading-one search, second half.
            r7_face <= r6_face;
            r7_neg  <= r6_neg;
            r7_mag  <= r6_mag;
            r7_bl   <= w7_bl;
            r7_zero <= w7_zero;

            // Shift so that the largest magnitude has exactly NMagW bits.
            r8_face <= r7_face;
            r8_neg  <= r7_neg;
            r8_zero <= r7_zero;
            for (int k = 0; k < 3; k++) begin
                if (r7_bl > BlW'(NMagW)) begin
                    r8_mag[k] <= NMagW'(r7_mag[k] >> (r7_bl - BlW'(NMagW)));
                end else begin
                    r8_mag[k] <= NMagW'(r7_mag[k] << (BlW'(NMagW) - r7_bl));
                end
            end

            // Squares.
            r9_face <= r8_face;
            r9_neg  <= r8_neg;
            r9_zero <= r8_zero;
            r9_mag  <= r8_mag;
            for (int k = 0; k < 3; k++) begin
                r9_sq[k] <= SqW'(r8_mag[k]) * SqW'(r8_mag[k]);
            end

            // Sum of squares.
            r10_face <= r9_face;
            r10_neg  <= r9_neg;
            r10_zero <= r9_zero;
            r10_mag  <= r9_mag;
            r10_sum  <= SumW'(r9_sq[0]) + SumW'(r9_sq[1]) + SumW'(r9_sq[2]);
        end
    end

    // Length of the normalized cross product.
    assign w_root_side_in = {r10_face, r10_neg, r10_zero, r10_mag[0], r10_mag[1], r10_mag[2]};

    tfn_isqrt #(
        .SIDE_W (RootSideW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r10_v),
        .i_x     (r10_sum),
        .i_side  (w_root_side_in),
        .o_valid (w_root_valid),
        .o_root  (w_root),
        .o_side  (w_root_side_out)
    );

    assign {w11_face, w11_neg, w11_zero, w11_mag[0], w11_mag[1], w11_mag[2]} = w_root_side_out;

    // Dividends carry half the divisor so that the quotient rounds half up.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r11_face <= w11_face;
            r11_neg  <= w11_neg;
            r11_zero <= w11_zero;
            r11_den  <= {w_root, 1'b0};
            for (int k = 0; k < 3; k++) begin
                r11_num[k] <= (NumW'(w11_mag[k]) << QShift) + NumW'(w_root);
            end
        end
    end

    tfn_div #(
        .SIDE_W (DivSideW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r11_v),
        .i_num   (r11_num),
        .i_den   (r11_den),
        .i_side  ({r11_face, r11_neg, r11_zero}),
        .o_valid (w_div_valid),
        .o_quot  (w_quot),
        .o_side  (w_div_side_out)
    );

    assign {w12_face, w12_neg, w12_zero} = w_div_side_out;

    // Clamp to one, apply the sign, and force zero for a degenerate face.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w12_clamp[k] = (w_quot[k] > QuotMax) ? QuotMax : w_quot[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r12_face <= w12_face;
            for (int k = 0; k < 3; k++) begin
                if (w12_zero) begin
                    r12_norm[k] <= '0;
                end else if (w12_neg[k]) begin
                    r12_norm[k] <= NormW'(0) - w12_clamp[k];
                end else begin
                    r12_norm[k] <= w12_clamp[k];
                end
            end
        end
    end

    assign o_valid    = r12_v;
    assign o_face     = r12_face;
    assign o_normal_x = r12_norm[0];
    assign o_normal_y = r12_norm[1];
    assign o_normal_z = r12_norm[2];

endmodule

`default_nettype wire

/* design/triangle_face_normal_expand.sv */
// Top level of the triangle face normal expander: fetch, normal pipeline, corner output.
// Depends on tfn_pkg, tfn_fetch and tfn_normal.
//
//   Channel   Direction  Handshake          Word
//   input     in         i_valid / o_stall  operation, vertex index, position, corners
//   result    out        o_valid / i_stall  corner position, face normal, last corner
//
// A vertex write needs one store write; a face needs one read per corner on the single
// vertex store read port, and gives three result words in corner order, which i_stall can hold.
// Most of the pipeline from a taken face to its first corner word lies in the square root
// (33 stages) and the divider (17 stages).
// Reset is synchronous, active low, and clears valid bits and sequencers, not the store.
// A waiting result word freezes the pipeline and raises o_stall only once a finished face
// stands behind it; empty stages keep draining meanwhile.
`default_nettype none

module triangle_face_normal_expand
    import tfn_pkg::*;
#(
    parameter int unsigned VERTEX_DEPTH = VertexDepthDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_operation,
    input  logic [IndexW-1:0]        i_vertex_index,
    input  logic signed [CoordW-1:0] i_pos_x_in,
    input  logic signed [CoordW-1:0] i_pos_y_in,
    input  logic signed [CoordW-1:0] i_pos_z_in,
    input  logic [IndexW-1:0]        i_corner_a,
    input  logic [IndexW-1:0]        i_corner_b,
    input  logic [IndexW-1:0]        i_corner_c,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [CoordW-1:0] o_pos_x_out,
    output logic signed [CoordW-1:0] o_pos_y_out,
    output logic signed [CoordW-1:0] o_pos_z_out,
    output logic signed [NormW-1:0]  o_normal_x,
    output logic signed [NormW-1:0]  o_normal_y,
    output logic signed [NormW-1:0]  o_normal_z,
    output logic                     o_last_corner
);

    logic                    w_en;
    logic                    w_take;
    logic                    w_load;
    logic                    w_face_valid;
    t_face                   w_face;
    logic                    w_norm_valid;
    t_face                   w_norm_face;
    logic signed [NormW-1:0] w_nx;
    logic signed [NormW-1:0] w_ny;
    logic signed [NormW-1:0] w_nz;

    logic                    r_hold;
    logic [1:0]              r_k;
    t_face                   r_face;
    logic signed [NormW-1:0] r_nx;
    logic signed [NormW-1:0] r_ny;
    logic signed [NormW-1:0] r_nz;
    t_pos                    w_pos;

    // The output register takes a new face when it is empty or gives up its last corner.
    assign w_take = r_hold && !i_stall;
    assign w_load = !r_hold || (w_take && (r_k == CornerC));

    // The pipeline moves unless a finished face waits for the output register.
    assign w_en   = w_load || !w_norm_valid;

    tfn_fetch #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_fetch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_vertex_index (i_vertex_index),
        .i_pos_x_in     (i_pos_x_in),
        .i_pos_y_in     (i_pos_y_in),
        .i_pos_z_in     (i_pos_z_in),
        .i_corner_a     (i_corner_a),
        .i_corner_b     (i_corner_b),
        .i_corner_c     (i_corner_c),
        .o_face_valid   (w_face_valid),
        .o_face         (w_face)
    );

    tfn_normal u_normal (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_face_valid),
        .i_face     (w_face),
        .o_valid    (w_norm_valid),
        .o_face     (w_norm_face),
        .o_normal_x (w_nx),
        .o_normal_y (w_ny),
        .o_normal_z (w_nz)
    );

    // Output register; it sends one corner word per cycle while i_stall is low.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_k    <= CornerA;
        end else if (w_load) begin
            r_hold <= w_norm_valid;
            r_k    <= CornerA;
        end else if (w_take) begin
            r_k <= r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_face <= w_norm_face;
            r_nx   <= w_nx;
            r_ny   <= w_ny;
            r_nz   <= w_nz;
        end
    end

    always_comb begin
        unique case (r_k)
            CornerA: w_pos = r_face.a;
            CornerB: w_pos = r_face.b;
            CornerC: w_pos = r_face.c;
            default: w_pos = r_face.a;
        endcase
    end

    assign o_valid       = r_hold;
    assign o_pos_x_out   = w_pos.x;
    assign o_pos_y_out   = w_pos.y;
    assign o_pos_z_out   = w_pos.z;
    assign o_normal_x    = r_nx;
    assign o_normal_y    = r_ny;
    assign o_normal_z    = r_nz;
    assign o_last_corner = (r_k == CornerC);

    // A taken corner that is not the last is followed by the next corner of the same face.
    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_corner) |=> (o_valid && r_k == $past(r_k) + 2'd1))
        else $error("corner sequence broken");

    // A blocked result word with a finished face behind it also blocks the input.
    a_back_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && w_norm_valid) |-> o_stall)
        else $error("input taken while output blocked");

    // The normal never exceeds unit length per component.
    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_normal_x) <= 16384 && $signed(o_normal_x) >= -16384
                     && $signed(o_normal_y) <= 16384 && $signed(o_normal_y) >= -16384
                     && $signed(o_normal_z) <= 16384 && $signed(o_normal_z) >= -16384))
        else $error("normal component out of range");

endmodule

`default_nettype wire
